>>> hdl/nus2x_pkg.sv
// Shared types, constants and helpers for the 2x nearest upsample address generator.
package nus2x_pkg;

   // Defaults for the top-level size parameters
   localparam int unsigned DEF_MAX_CHAN   = 64;
   localparam int unsigned DEF_MAX_IN_DIM = 1024;
   localparam int unsigned DEF_MAX_IMAGES = 16;

   // Field widths
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned INDEX_W  = 32;
   localparam int unsigned CHAN_RW  = 7;
   localparam int unsigned DIM_RW   = 11;
   localparam int unsigned BATCH_RW = 5;
   localparam int unsigned CSR_AW   = 8;
   localparam int unsigned CSR_DW   = 32;

   // channels * in_width product width
   localparam int unsigned PROD_W = CHAN_RW + DIM_RW;

   // Front-to-back queue (power of two so pointers wrap on their own)
   localparam int unsigned FIFO_DEPTH = 2;
   localparam int unsigned FIFO_PW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [CSR_AW-1:0] {
      REG_CHANNELS    = 8'd0,
      REG_IN_WIDTH    = 8'd1,
      REG_IN_HEIGHT   = 8'd2,
      REG_BATCH_COUNT = 8'd3
   } nus2x_reg_type;

   localparam logic [1:0] CORNER_UL = 2'd0;
   localparam logic [1:0] CORNER_UR = 2'd1;
   localparam logic [1:0] CORNER_LL = 2'd2;
   localparam logic [1:0] CORNER_LR = 2'd3;

   // Geometry as used by the datapath (already clamped to legal range)
   typedef struct packed {
      logic [CHAN_RW-1:0]  channels;
      logic [DIM_RW-1:0]   in_width;
      logic [DIM_RW-1:0]   in_height;
      logic [BATCH_RW-1:0] batch_count;
   } nus2x_cfg_type;

   // One classified input element: upper-left output index and value
   typedef struct packed {
      logic [INDEX_W-1:0] ul_index;
      logic [DATA_W-1:0]  value;
      logic               job_end;
   } nus2x_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } nus2x_fifo_stat_type;

   // Zero reads as one, anything above the limit reads as the limit
   function automatic logic [31:0] clamp_val(input logic [31:0] v, input logic [31:0] hi);
      logic [31:0] r;
      r = v;
      if (v == 32'd0) begin
         r = 32'd1;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

>>> hdl/nus2x_ifs.sv
// Valid/ready channel interfaces: input samples, result beats and register writes.
interface nus2x_req_if
   import nus2x_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface nus2x_rsp_if
   import nus2x_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] out_index;
   logic [DATA_W-1:0]  out_value;
   logic [1:0]         corner;
   logic               last_of_item;
   logic               end_of_job;

   modport source (output valid, output out_index, output out_value, output corner,
                   output last_of_item, output end_of_job, input ready);
   modport sink   (input valid, input out_index, input out_value, input corner,
                   input last_of_item, input end_of_job, output ready);
endinterface

interface nus2x_csr_if
   import nus2x_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CSR_AW-1:0] reg_index;
   logic [CSR_DW-1:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> hdl/nus2x_csr.sv
// Geometry registers: clamp on write, restart pulse on every known write.
module nus2x_csr
   import nus2x_pkg::*;
#(
   parameter int unsigned MAX_CHAN   = DEF_MAX_CHAN,
   parameter int unsigned MAX_IN_DIM = DEF_MAX_IN_DIM,
   parameter int unsigned MAX_IMAGES = DEF_MAX_IMAGES
) (
   input  logic          clock,
   input  logic          reset,
   nus2x_csr_if.sink     csr,
   output nus2x_cfg_type cfg,
   output logic          restart
);

   nus2x_cfg_type cfg_ff, cfg_in;
   logic          hit;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b0;
      if (csr.valid) begin
         case (csr.reg_index)
            REG_CHANNELS: begin
               cfg_in.channels = CHAN_RW'(clamp_val(32'(csr.wdata[CHAN_RW-1:0]),
                                                    32'(MAX_CHAN)));
               hit = 1'b1;
            end
            REG_IN_WIDTH: begin
               cfg_in.in_width = DIM_RW'(clamp_val(32'(csr.wdata[DIM_RW-1:0]),
                                                   32'(MAX_IN_DIM)));
               hit = 1'b1;
            end
            REG_IN_HEIGHT: begin
               cfg_in.in_height = DIM_RW'(clamp_val(32'(csr.wdata[DIM_RW-1:0]),
                                                    32'(MAX_IN_DIM)));
               hit = 1'b1;
            end
            REG_BATCH_COUNT: begin
               cfg_in.batch_count = BATCH_RW'(clamp_val(32'(csr.wdata[BATCH_RW-1:0]),
                                                        32'(MAX_IMAGES)));
               hit = 1'b1;
            end
            default: begin
               hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channels    <= CHAN_RW'(1);
         cfg_ff.in_width    <= DIM_RW'(1);
         cfg_ff.in_height   <= DIM_RW'(1);
         cfg_ff.batch_count <= BATCH_RW'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg     = cfg_ff;
   assign restart = hit;

endmodule

>>> hdl/nus2x_front.sv
// Front end: takes samples, walks the position counters, emits upper-left indexes.
module nus2x_front
   import nus2x_pkg::*;
#(
   parameter int unsigned MAX_CHAN   = DEF_MAX_CHAN,
   parameter int unsigned MAX_IN_DIM = DEF_MAX_IN_DIM,
   parameter int unsigned MAX_IMAGES = DEF_MAX_IMAGES
) (
   input  logic                clock,
   input  logic                reset,
   nus2x_req_if.sink           req,
   input  nus2x_cfg_type       cfg,
   input  logic                restart,
   input  nus2x_fifo_stat_type fstat,
   output logic                push,
   output nus2x_entry_type     entry
);

   localparam int unsigned CHAN_W = (MAX_CHAN > 1)   ? $clog2(MAX_CHAN)   : 1;
   localparam int unsigned DIM_W  = (MAX_IN_DIM > 1) ? $clog2(MAX_IN_DIM) : 1;
   localparam int unsigned IMG_W  = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;

   logic [CHAN_W-1:0]  chan_pos_ff, chan_pos_in;
   logic [DIM_W-1:0]   col_pos_ff, col_pos_in;
   logic [DIM_W-1:0]   row_pos_ff, row_pos_in;
   logic [IMG_W-1:0]   image_pos_ff, image_pos_in;
   // pix_ptr: output index of channel 0 of the current pixel's UL corner
   // row_ptr: output index of the current input row's first UL element
   logic [INDEX_W-1:0] pix_ptr_ff, pix_ptr_in;
   logic [INDEX_W-1:0] row_ptr_ff, row_ptr_in;

   logic               last_chan, last_col, last_row, last_img, job_end;
   logic [PROD_W-1:0]  chan_x_width;
   logic [INDEX_W-1:0] row_step, pix_step, next_row;

   assign req.ready = !fstat.full;
   assign push      = req.valid && !fstat.full;

   assign last_chan = (32'(chan_pos_ff)  + 32'd1) >= 32'(cfg.channels);
   assign last_col  = (32'(col_pos_ff)   + 32'd1) >= 32'(cfg.in_width);
   assign last_row  = (32'(row_pos_ff)   + 32'd1) >= 32'(cfg.in_height);
   assign last_img  = (32'(image_pos_ff) + 32'd1) >= 32'(cfg.batch_count);
   assign job_end   = last_chan && last_col && last_row && last_img;

   // Two output rows per input row: 2 * channels * (2 * in_width)
   assign chan_x_width = PROD_W'(cfg.channels) * PROD_W'(cfg.in_width);
   assign row_step     = INDEX_W'(chan_x_width) << 2;
   assign pix_step     = INDEX_W'(cfg.channels) << 1;
   assign next_row     = row_ptr_ff + row_step;

   assign entry.ul_index = pix_ptr_ff + INDEX_W'(chan_pos_ff);
   assign entry.value    = req.sample;
   assign entry.job_end  = job_end;

   always_comb begin
      chan_pos_in  = chan_pos_ff;
      col_pos_in   = col_pos_ff;
      row_pos_in   = row_pos_ff;
      image_pos_in = image_pos_ff;
      pix_ptr_in   = pix_ptr_ff;
      row_ptr_in   = row_ptr_ff;
      if (restart || (push && job_end)) begin
         chan_pos_in  = '0;
         col_pos_in   = '0;
         row_pos_in   = '0;
         image_pos_in = '0;
         pix_ptr_in   = '0;
         row_ptr_in   = '0;
      end else if (push) begin
         if (!last_chan) begin
            chan_pos_in = chan_pos_ff + CHAN_W'(1);
         end else begin
            chan_pos_in = '0;
            if (!last_col) begin
               col_pos_in = col_pos_ff + DIM_W'(1);
               pix_ptr_in = pix_ptr_ff + pix_step;
            end else begin
               // next row (or next image, whose base follows the last row)
               col_pos_in = '0;
               pix_ptr_in = next_row;
               row_ptr_in = next_row;
               if (!last_row) begin
                  row_pos_in = row_pos_ff + DIM_W'(1);
               end else begin
                  row_pos_in   = '0;
                  image_pos_in = image_pos_ff + IMG_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_pos_ff  <= '0;
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         image_pos_ff <= '0;
         pix_ptr_ff   <= '0;
         row_ptr_ff   <= '0;
      end else begin
         chan_pos_ff  <= chan_pos_in;
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         image_pos_ff <= image_pos_in;
         pix_ptr_ff   <= pix_ptr_in;
         row_ptr_ff   <= row_ptr_in;
      end
   end

   a_job_end_clears: assert property (@(posedge clock) disable iff (reset)
      push && job_end |=> chan_pos_ff == '0 && col_pos_ff == '0 && row_pos_ff == '0
                          && image_pos_ff == '0 && pix_ptr_ff == '0)
      else $error("counters not cleared after end of job");

endmodule

>>> hdl/nus2x_fifo.sv
// Short queue of classified elements between the front and back ends.
module nus2x_fifo
   import nus2x_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nus2x_entry_type     wr_entry,
   input  logic                pop,
   output nus2x_entry_type     rd_entry,
   output nus2x_fifo_stat_type fstat
);

   nus2x_entry_type     mem [FIFO_DEPTH];
   logic [FIFO_PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]  count_ff, count_in;
   logic                do_push, do_pop;

   assign fstat.full  = count_ff == FIFO_CW'(FIFO_DEPTH);
   assign fstat.empty = count_ff == '0;
   assign do_push     = push && !fstat.full;
   assign do_pop      = pop && !fstat.empty;
   assign rd_entry    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + FIFO_PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CW'(FIFO_DEPTH))
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fstat.empty)
      else $error("pop from empty queue");

endmodule

>>> hdl/nus2x_back.sv
// Back end: expands each element into four corner beats behind an output register.
module nus2x_back
   import nus2x_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  nus2x_cfg_type       cfg,
   input  nus2x_entry_type     head,
   input  nus2x_fifo_stat_type fstat,
   output logic                pop,
   nus2x_rsp_if.source         rsp
);

   nus2x_entry_type    cur_ff;
   logic               cur_valid_ff, cur_valid_in;
   logic [1:0]         corner_ff, corner_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] out_index_ff;
   logic [DATA_W-1:0]  out_value_ff;
   logic [1:0]         out_corner_ff;
   logic               out_last_ff;
   logic               out_end_ff;

   logic               out_free, emit, done;
   logic [PROD_W-1:0]  chan_x_width;
   logic [INDEX_W-1:0] row_off, offset;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit     = out_free && cur_valid_ff;
   assign done     = emit && (corner_ff == CORNER_LR);
   assign pop      = (!cur_valid_ff || done) && !fstat.empty;

   // one output row = channels * 2 * in_width elements
   assign chan_x_width = PROD_W'(cfg.channels) * PROD_W'(cfg.in_width);
   assign row_off      = INDEX_W'(chan_x_width) << 1;

   always_comb begin
      case (corner_ff)
         CORNER_UL: offset = '0;
         CORNER_UR: offset = INDEX_W'(cfg.channels);
         CORNER_LL: offset = row_off;
         CORNER_LR: offset = row_off + INDEX_W'(cfg.channels);
         default:   offset = '0;
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      corner_in    = corner_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         corner_in    = CORNER_UL;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         corner_in = corner_ff + 2'd1;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         corner_ff    <= CORNER_UL;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
      if (emit) begin
         out_index_ff  <= cur_ff.ul_index + offset;
         out_value_ff  <= cur_ff.value;
         out_corner_ff <= corner_ff;
         out_last_ff   <= corner_ff == CORNER_LR;
         out_end_ff    <= (corner_ff == CORNER_LR) && cur_ff.job_end;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_index    = out_index_ff;
   assign rsp.out_value    = out_value_ff;
   assign rsp.corner       = out_corner_ff;
   assign rsp.last_of_item = out_last_ff;
   assign rsp.end_of_job   = out_end_ff;

   a_burst_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp.ready && out_corner_ff != CORNER_LR |=> rsp_valid_ff)
      else $error("gap inside the four beats of one element");

endmodule

>>> hdl/nearest_upsample_2x_addr_gen_unit.sv
// Top level of the 2x nearest-neighbor upsample address generator.
// Each accepted 32-bit sample of a channel-last batch (image, row, column,
// channel order) becomes four result beats carrying the sample unchanged and
// the flat output index of its upper-left, upper-right, lower-left and
// lower-right copy in the doubled image, in that corner order. The fourth beat
// sets last_of_item; the fourth beat of the batch's final sample also sets
// end_of_job; the counters wrap, starting a new job, once that sample is taken.
// Register writes (0 channels, 1 in_width, 2 in_height, 3 batch_count) keep
// its low field-width bits, clamp zero to one and values over MAX_* to MAX_*,
// and restart the job; unknown indexes are dropped. Write them only while no
// beats are pending. Each sample holds the result channel for four beats; it
// moves one beat per cycle while ready is high. The front end takes a sample
// per cycle into a 2-entry queue while the queue is not full, and the back
// end runs from a registered output stage, so input and output stall
// independently; a sample passes the queue, element and output registers.
module nearest_upsample_2x_addr_gen_unit
   import nus2x_pkg::*;
#(
   parameter int unsigned MAX_CHAN   = DEF_MAX_CHAN,
   parameter int unsigned MAX_IN_DIM = DEF_MAX_IN_DIM,
   parameter int unsigned MAX_IMAGES = DEF_MAX_IMAGES
) (
   input  logic         clock,
   input  logic         reset,
   nus2x_req_if.sink    req_chan,
   nus2x_rsp_if.source  rsp_chan,
   nus2x_csr_if.sink    csr_chan
);

   nus2x_cfg_type       cfg;
   logic                restart;
   nus2x_fifo_stat_type fstat;
   logic                push, pop;
   nus2x_entry_type     wr_entry, head;

   // geometry registers
   nus2x_csr #(
      .MAX_CHAN   (MAX_CHAN),
      .MAX_IN_DIM (MAX_IN_DIM),
      .MAX_IMAGES (MAX_IMAGES)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr_chan),
      .cfg     (cfg),
      .restart (restart)
   );

   // position counters, upper-left index per sample
   nus2x_front #(
      .MAX_CHAN   (MAX_CHAN),
      .MAX_IN_DIM (MAX_IN_DIM),
      .MAX_IMAGES (MAX_IMAGES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .cfg     (cfg),
      .restart (restart),
      .fstat   (fstat),
      .push    (push),
      .entry   (wr_entry)
   );

   // decoupling queue
   nus2x_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (wr_entry),
      .pop      (pop),
      .rd_entry (head),
      .fstat    (fstat)
   );

   // four-corner expansion and output register
   nus2x_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .head  (head),
      .fstat (fstat),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule
